// File: rtl/lobm_pkg.sv
// Shared types and constants of the limit order book matcher.
// Used by lobm_datapath, lobm_ctrl and the top level.
package lobm_pkg;

    // Book geometry
    localparam int MAX_ORDERS  = 1024;
    localparam int PRICE_TICKS = 1024;
    localparam int QTY_W       = 20;
    localparam int ORD_AW      = $clog2(MAX_ORDERS);
    localparam int PRICE_W     = $clog2(PRICE_TICKS);
    localparam int LVL_AW      = PRICE_W + 1;
    localparam int LVL_DEPTH   = 2 * PRICE_TICKS;
    localparam int TOT_W       = QTY_W + ORD_AW;
    localparam int TRADE_CNT_W = 6;

    // Command codes
    localparam logic [2:0] CMD_LIMIT  = 3'd0;
    localparam logic [2:0] CMD_MARKET = 3'd1;
    localparam logic [2:0] CMD_ADD    = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_PRUNE  = 3'd4;

    // Status codes
    localparam logic [2:0] STAT_FILLED   = 3'd0;
    localparam logic [2:0] STAT_PARTIAL  = 3'd1;
    localparam logic [2:0] STAT_OPEN     = 3'd2;
    localparam logic [2:0] STAT_NO_LIQ   = 3'd3;
    localparam logic [2:0] STAT_ACCEPTED = 3'd4;
    localparam logic [2:0] STAT_REJECTED = 3'd5;

    // Record kinds
    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Order slot record
    typedef struct packed {
        logic               valid;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic               day;
    } t_slot_rec;

    // Price level record
    typedef struct packed {
        logic [ORD_AW-1:0] head;
        logic [ORD_AW-1:0] tail;
        logic [TOT_W-1:0]  total;
    } t_lvl_rec;

    // Datapath micro operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLR,
        OP_LOAD,
        OP_RD_SLOT,
        OP_RD_HEAD,
        OP_PRUNE_INIT,
        OP_INC_O,
        OP_SEL_LVL,
        OP_RD_LVL_CUR,
        OP_RD_LVL_SLOT,
        OP_RD_LVL_NEW,
        OP_EMIT_TRADE,
        OP_EMIT_STAT,
        OP_PART,
        OP_UNLINK,
        OP_REST,
        OP_RS_INIT,
        OP_RS_RD,
        OP_RS_HIT,
        OP_RS_STEP
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] st;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       slot_valid;
        logic       slot_day;
        logic       q_zero;
        logic       q_ge;
        logic       lvl_ok;
        logic       lvl_nz;
        logic       new_empty;
        logic       cap;
        logic       scan_end;
        logic       o_last;
        logic       clr_done;
        logic       out_free;
    } t_dp_stat;

endpackage

// File: rtl/lobm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lobm_datapath.sv
// Datapath of the order book: order and level stores, best prices,
// working registers and the result register. Uses lobm_pkg and lobm_ram.
module lobm_datapath
    import lobm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_dp_cmd,
    output t_dp_stat            o_dp_stat,
    input  logic [2:0]          i_command,
    input  logic [ORD_AW-1:0]   i_order_id,
    input  logic                i_order_side,
    input  logic [PRICE_W-1:0]  i_order_price,
    input  logic [QTY_W-1:0]    i_order_quantity,
    input  logic                i_good_for_day,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_record_kind,
    output logic                o_trade_side,
    output logic [PRICE_W-1:0]  o_trade_price,
    output logic [QTY_W-1:0]    o_trade_quantity,
    output logic [2:0]          o_status,
    output logic [QTY_W-1:0]    o_executed_total,
    output logic [QTY_W-1:0]    o_remaining_quantity,
    output logic                o_last
);

    localparam logic [PRICE_W:0] NO_PRICE = (PRICE_W+1)'(PRICE_TICKS);

    // RAM ports
    t_slot_rec           s_rd, s_wdata;
    logic                s_we, s_re;
    logic [ORD_AW-1:0]   s_waddr, s_raddr;
    logic [ORD_AW-1:0]   nx_rd, nx_waddr, nx_wdata;
    logic                nx_we;
    logic [ORD_AW-1:0]   pv_rd, pv_waddr, pv_wdata;
    logic                pv_we;
    t_lvl_rec            l_rd, l_wdata;
    logic                l_we, l_re;
    logic [LVL_AW-1:0]   l_waddr, l_raddr;

    // working registers
    logic [2:0]             r_cmd, n_cmd;
    logic [ORD_AW-1:0]      r_id, n_id;
    logic                   r_side, n_side;
    logic [PRICE_W-1:0]     r_price, n_price;
    logic [QTY_W-1:0]       r_qty, n_qty;
    logic                   r_day, n_day;
    logic [QTY_W-1:0]       r_q, n_q;
    logic [QTY_W-1:0]       r_start, n_start;
    logic [TRADE_CNT_W-1:0] r_ntrade, n_ntrade;
    logic [LVL_AW-1:0]      r_lv, n_lv;
    logic [ORD_AW-1:0]      r_o, n_o;
    logic [PRICE_W-1:0]     r_scan, n_scan;
    logic [LVL_AW-1:0]      r_clr, n_clr;
    logic [PRICE_W:0]       r_best_bid, n_best_bid;
    logic [PRICE_W:0]       r_best_ask, n_best_ask;

    // result register
    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic               r_oside, n_oside;
    logic [PRICE_W-1:0] r_oprice, n_oprice;
    logic [QTY_W-1:0]   r_tq, n_tq;
    logic [2:0]         r_st, n_st;
    logic [QTY_W-1:0]   r_ex, n_ex;
    logic [QTY_W-1:0]   r_rem, n_rem;
    logic               r_last, n_last;

    logic [PRICE_W:0]   opp_best;
    logic               crosses;
    logic               is_match_cmd;
    logic               is_order_cmd;
    logic [TOT_W-1:0]   slot_qty_ext;
    logic [TOT_W-1:0]   q_ext;

    // stores
    lobm_ram #(.WIDTH($bits(t_slot_rec)), .DEPTH(MAX_ORDERS)) u_slot_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rd)
    );
    lobm_ram #(.WIDTH(ORD_AW), .DEPTH(MAX_ORDERS)) u_next_ram (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(nx_rd)
    );
    lobm_ram #(.WIDTH(ORD_AW), .DEPTH(MAX_ORDERS)) u_prev_ram (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(pv_rd)
    );
    lobm_ram #(.WIDTH($bits(t_lvl_rec)), .DEPTH(LVL_DEPTH)) u_level_ram (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_re(l_re), .i_raddr(l_raddr), .o_rdata(l_rd)
    );

    // crossing test against the best opposite level
    assign opp_best     = r_side ? r_best_bid : r_best_ask;
    assign crosses      = r_side ? (opp_best[PRICE_W-1:0] >= r_price)
                                 : (opp_best[PRICE_W-1:0] <= r_price);
    assign is_match_cmd = (r_cmd == CMD_LIMIT) || (r_cmd == CMD_MARKET);
    assign is_order_cmd = is_match_cmd || (r_cmd == CMD_ADD);
    assign slot_qty_ext = {{(TOT_W-QTY_W){1'b0}}, s_rd.qty};
    assign q_ext        = {{(TOT_W-QTY_W){1'b0}}, r_q};

    // status toward the controller
    always_comb begin
        o_dp_stat.cmd        = r_cmd;
        o_dp_stat.slot_valid = s_rd.valid;
        o_dp_stat.slot_day   = s_rd.day;
        o_dp_stat.q_zero     = (r_q == '0);
        o_dp_stat.q_ge       = (r_q >= s_rd.qty);
        o_dp_stat.lvl_ok     = !opp_best[PRICE_W] && ((r_cmd == CMD_MARKET) || crosses);
        o_dp_stat.lvl_nz     = (l_rd.total != '0);
        o_dp_stat.new_empty  = (l_rd.total == slot_qty_ext);
        o_dp_stat.cap        = &r_ntrade;
        o_dp_stat.scan_end   = r_lv[PRICE_W] ? (&r_scan) : (r_scan == '0);
        o_dp_stat.o_last     = &r_o;
        o_dp_stat.clr_done   = &r_clr;
        o_dp_stat.out_free   = !r_out_valid || i_out_ready;
    end

    // micro operation decode
    always_comb begin
        n_cmd = r_cmd;   n_id = r_id;     n_side = r_side;  n_price = r_price;
        n_qty = r_qty;   n_day = r_day;   n_q = r_q;        n_start = r_start;
        n_ntrade = r_ntrade; n_lv = r_lv; n_o = r_o;        n_scan = r_scan;
        n_clr = r_clr;   n_best_bid = r_best_bid;           n_best_ask = r_best_ask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind = r_kind; n_oside = r_oside; n_oprice = r_oprice; n_tq = r_tq;
        n_st = r_st;     n_ex = r_ex;       n_rem = r_rem;       n_last = r_last;

        s_re = 1'b0;  s_raddr = r_o;
        s_we = 1'b0;  s_waddr = r_o;  s_wdata = s_rd;
        nx_we = 1'b0; nx_waddr = pv_rd; nx_wdata = nx_rd;
        pv_we = 1'b0; pv_waddr = nx_rd; pv_wdata = pv_rd;
        l_re = 1'b0;  l_raddr = r_lv;
        l_we = 1'b0;  l_waddr = r_lv;   l_wdata = l_rd;

        unique case (i_dp_cmd.op)
            OP_NOP: begin
            end
            // clearing pass over both stores
            OP_CLR: begin
                s_we    = !r_clr[LVL_AW-1];
                s_waddr = r_clr[ORD_AW-1:0];
                s_wdata = '0;
                l_we    = 1'b1;
                l_waddr = r_clr;
                l_wdata = '0;
                n_clr   = r_clr + 1'b1;
            end
            OP_LOAD: begin
                n_cmd    = i_command;
                n_id     = i_order_id;
                n_side   = i_order_side;
                n_price  = i_order_price;
                n_qty    = i_order_quantity;
                n_day    = i_good_for_day;
                n_q      = i_order_quantity;
                n_o      = i_order_id;
                n_ntrade = '0;
            end
            OP_RD_SLOT: begin
                s_re = 1'b1;
            end
            OP_RD_HEAD: begin
                s_re    = 1'b1;
                s_raddr = l_rd.head;
                n_o     = l_rd.head;
            end
            OP_PRUNE_INIT: n_o = '0;
            OP_INC_O:      n_o = r_o + 1'b1;
            OP_SEL_LVL: begin
                n_lv    = {!r_side, opp_best[PRICE_W-1:0]};
                n_start = r_q;
            end
            OP_RD_LVL_CUR: l_re = 1'b1;
            OP_RD_LVL_SLOT: begin
                l_re    = 1'b1;
                l_raddr = {s_rd.side, s_rd.price};
                n_lv    = {s_rd.side, s_rd.price};
            end
            OP_RD_LVL_NEW: begin
                l_re    = 1'b1;
                l_raddr = {r_side, r_price};
                n_lv    = {r_side, r_price};
            end
            OP_EMIT_TRADE: begin
                n_out_valid = 1'b1;
                n_kind   = KIND_TRADE;
                n_oside  = r_side;
                n_oprice = r_lv[PRICE_W-1:0];
                n_tq     = r_start - r_q;
                n_st     = STAT_FILLED;
                n_ex     = '0;
                n_rem    = '0;
                n_last   = 1'b0;
                n_ntrade = r_ntrade + 1'b1;
            end
            OP_EMIT_STAT: begin
                n_out_valid = 1'b1;
                n_kind   = KIND_STATUS;
                n_oside  = is_order_cmd ? r_side : 1'b0;
                n_oprice = ((r_cmd == CMD_LIMIT) || (r_cmd == CMD_ADD)) ? r_price : '0;
                n_tq     = '0;
                n_st     = i_dp_cmd.st;
                n_ex     = is_match_cmd ? (r_qty - r_q) : '0;
                n_rem    = is_order_cmd ? r_q : '0;
                n_last   = 1'b1;
            end
            // resting head order only partly filled
            OP_PART: begin
                s_we          = 1'b1;
                s_wdata.qty   = s_rd.qty - r_q;
                l_we          = 1'b1;
                l_wdata.total = l_rd.total - q_ext;
                n_q           = '0;
            end
            // take slot r_o out of its level FIFO
            OP_UNLINK: begin
                if (l_rd.head == r_o) begin
                    if (l_rd.tail != r_o) begin
                        l_wdata.head = nx_rd;
                    end
                end else if (l_rd.tail == r_o) begin
                    l_wdata.tail = pv_rd;
                end else begin
                    nx_we = 1'b1;
                    pv_we = 1'b1;
                end
                l_we          = 1'b1;
                l_wdata.total = l_rd.total - slot_qty_ext;
                s_we          = 1'b1;
                s_wdata.valid = 1'b0;
                n_q           = r_q - s_rd.qty;
            end
            // append order r_id to the tail of level r_lv
            OP_REST: begin
                s_we    = 1'b1;
                s_waddr = r_id;
                s_wdata = '{valid: 1'b1, side: r_side, price: r_price, qty: r_q, day: r_day};
                l_we    = 1'b1;
                if (l_rd.total == '0) begin
                    l_wdata.head = r_id;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = l_rd.tail;
                    nx_wdata = r_id;
                    pv_we    = 1'b1;
                    pv_waddr = r_id;
                    pv_wdata = l_rd.tail;
                end
                l_wdata.tail  = r_id;
                l_wdata.total = l_rd.total + q_ext;
                if (!r_side) begin
                    if (r_best_bid[PRICE_W] || (r_price > r_best_bid[PRICE_W-1:0])) begin
                        n_best_bid = {1'b0, r_price};
                    end
                end else begin
                    if (r_best_ask[PRICE_W] || (r_price < r_best_ask[PRICE_W-1:0])) begin
                        n_best_ask = {1'b0, r_price};
                    end
                end
            end
            // best price rescan of side r_lv[top]
            OP_RS_INIT: begin
                if (!r_lv[PRICE_W]) begin
                    n_best_bid = NO_PRICE;
                    n_scan     = '1;
                end else begin
                    n_best_ask = NO_PRICE;
                    n_scan     = '0;
                end
            end
            OP_RS_RD: begin
                l_re    = 1'b1;
                l_raddr = {r_lv[PRICE_W], r_scan};
            end
            OP_RS_HIT: begin
                if (!r_lv[PRICE_W]) begin
                    n_best_bid = {1'b0, r_scan};
                end else begin
                    n_best_ask = {1'b0, r_scan};
                end
            end
            OP_RS_STEP: n_scan = r_lv[PRICE_W] ? (r_scan + 1'b1) : (r_scan - 1'b1);
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_best_bid  <= NO_PRICE;
            r_best_ask  <= NO_PRICE;
            r_out_valid <= 1'b0;
        end else begin
            r_clr       <= n_clr;
            r_best_bid  <= n_best_bid;
            r_best_ask  <= n_best_ask;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;   r_id <= n_id;     r_side <= n_side;  r_price <= n_price;
        r_qty <= n_qty;   r_day <= n_day;   r_q <= n_q;        r_start <= n_start;
        r_ntrade <= n_ntrade; r_lv <= n_lv; r_o <= n_o;        r_scan <= n_scan;
        r_kind <= n_kind; r_oside <= n_oside; r_oprice <= n_oprice; r_tq <= n_tq;
        r_st <= n_st;     r_ex <= n_ex;     r_rem <= n_rem;    r_last <= n_last;
    end

    assign o_out_valid          = r_out_valid;
    assign o_record_kind        = r_kind;
    assign o_trade_side         = r_oside;
    assign o_trade_price        = r_oprice;
    assign o_trade_quantity     = r_tq;
    assign o_status             = r_st;
    assign o_executed_total     = r_ex;
    assign o_remaining_quantity = r_rem;
    assign o_last               = r_last;

endmodule

// File: rtl/lobm_ctrl.sv
// Controller state machine of the order book: sequences datapath operations
// for matching, resting, cancel, prune and best price rescans. Uses lobm_pkg.
module lobm_ctrl
    import lobm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_dp_stat,
    output t_dp_cmd  o_dp_cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ID,
        ST_DISPATCH,
        ST_M_CHK,
        ST_M_LRD,
        ST_M_LCK,
        ST_M_SCK,
        ST_U_LRD,
        ST_U_APPLY,
        ST_RS_INIT,
        ST_RS_RD,
        ST_RS_CK,
        ST_RE_RD,
        ST_RE_WR,
        ST_P_RD,
        ST_P_CK,
        ST_P_NEXT,
        ST_STAT
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_st, n_st;
    logic       r_crossed, n_crossed;
    t_state     ret_state;

    // where to go once an unlink (and any rescan) is done
    always_comb begin
        priority if (i_dp_stat.cmd == CMD_CANCEL) begin
            ret_state = ST_STAT;
        end else if (i_dp_stat.cmd == CMD_PRUNE) begin
            ret_state = ST_P_NEXT;
        end else begin
            ret_state = ST_M_LRD;
        end
    end

    // next state and datapath operation
    always_comb begin
        n_state     = r_state;
        n_st        = r_st;
        n_crossed   = r_crossed;
        o_dp_cmd.op = OP_NOP;
        o_dp_cmd.st = r_st;
        unique case (r_state)
            ST_CLEAR: begin
                o_dp_cmd.op = OP_CLR;
                if (i_dp_stat.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_dp_cmd.op = OP_LOAD;
                    n_state     = ST_RD_ID;
                end
            end
            ST_RD_ID: begin
                o_dp_cmd.op = OP_RD_SLOT;
                n_state     = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                n_st    = STAT_REJECTED;
                n_state = ST_STAT;
                unique case (i_dp_stat.cmd)
                    CMD_LIMIT: begin
                        if (!i_dp_stat.slot_valid) begin
                            if (i_dp_stat.lvl_ok) begin
                                n_crossed = 1'b1;
                                n_state   = ST_M_CHK;
                            end else if (!i_dp_stat.q_zero) begin
                                n_crossed = 1'b0;
                                n_state   = ST_RE_RD;
                            end
                        end
                    end
                    CMD_MARKET: begin
                        if (i_dp_stat.lvl_ok) begin
                            n_state = ST_M_CHK;
                        end else begin
                            n_st = STAT_NO_LIQ;
                        end
                    end
                    CMD_ADD: begin
                        if (!i_dp_stat.slot_valid && !i_dp_stat.q_zero) begin
                            n_state = ST_RE_RD;
                        end
                    end
                    CMD_CANCEL: begin
                        if (i_dp_stat.slot_valid) begin
                            n_state = ST_U_LRD;
                        end
                    end
                    CMD_PRUNE: begin
                        o_dp_cmd.op = OP_PRUNE_INIT;
                        n_state     = ST_P_RD;
                    end
                    default: begin
                    end
                endcase
            end
            // pick the next level to match against, or finish
            ST_M_CHK: begin
                if (i_dp_stat.q_zero || i_dp_stat.cap || !i_dp_stat.lvl_ok) begin
                    if (i_dp_stat.q_zero) begin
                        n_st    = STAT_FILLED;
                        n_state = ST_STAT;
                    end else if (i_dp_stat.cmd == CMD_LIMIT) begin
                        n_state = ST_RE_RD;
                    end else begin
                        n_st    = STAT_PARTIAL;
                        n_state = ST_STAT;
                    end
                end else begin
                    o_dp_cmd.op = OP_SEL_LVL;
                    n_state     = ST_M_LRD;
                end
            end
            ST_M_LRD: begin
                o_dp_cmd.op = OP_RD_LVL_CUR;
                n_state     = ST_M_LCK;
            end
            ST_M_LCK: begin
                if (i_dp_stat.q_zero || !i_dp_stat.lvl_nz) begin
                    if (i_dp_stat.out_free) begin
                        o_dp_cmd.op = OP_EMIT_TRADE;
                        n_state     = ST_M_CHK;
                    end
                end else begin
                    o_dp_cmd.op = OP_RD_HEAD;
                    n_state     = ST_M_SCK;
                end
            end
            ST_M_SCK: begin
                if (i_dp_stat.q_ge) begin
                    o_dp_cmd.op = OP_UNLINK;
                    n_state     = i_dp_stat.new_empty ? ST_RS_INIT : ST_M_LRD;
                end else begin
                    o_dp_cmd.op = OP_PART;
                    n_state     = ST_M_LRD;
                end
            end
            // unlink of a resting order
            ST_U_LRD: begin
                o_dp_cmd.op = OP_RD_LVL_SLOT;
                n_state     = ST_U_APPLY;
            end
            ST_U_APPLY: begin
                o_dp_cmd.op = OP_UNLINK;
                n_st        = STAT_ACCEPTED;
                n_state     = i_dp_stat.new_empty ? ST_RS_INIT : ret_state;
            end
            // best price rescan
            ST_RS_INIT: begin
                o_dp_cmd.op = OP_RS_INIT;
                n_state     = ST_RS_RD;
            end
            ST_RS_RD: begin
                o_dp_cmd.op = OP_RS_RD;
                n_state     = ST_RS_CK;
            end
            ST_RS_CK: begin
                n_st = STAT_ACCEPTED;
                if (i_dp_stat.lvl_nz) begin
                    o_dp_cmd.op = OP_RS_HIT;
                    n_state     = ret_state;
                end else if (i_dp_stat.scan_end) begin
                    n_state = ret_state;
                end else begin
                    o_dp_cmd.op = OP_RS_STEP;
                    n_state     = ST_RS_RD;
                end
            end
            // rest the order on its level
            ST_RE_RD: begin
                o_dp_cmd.op = OP_RD_LVL_NEW;
                n_state     = ST_RE_WR;
            end
            ST_RE_WR: begin
                o_dp_cmd.op = OP_REST;
                n_state     = ST_STAT;
                priority if (i_dp_stat.cmd == CMD_ADD) begin
                    n_st = STAT_ACCEPTED;
                end else if (r_crossed) begin
                    n_st = STAT_PARTIAL;
                end else begin
                    n_st = STAT_OPEN;
                end
            end
            // prune walk over all slots
            ST_P_RD: begin
                o_dp_cmd.op = OP_RD_SLOT;
                n_state     = ST_P_CK;
            end
            ST_P_CK: begin
                n_state = (i_dp_stat.slot_valid && i_dp_stat.slot_day) ? ST_U_LRD : ST_P_NEXT;
            end
            ST_P_NEXT: begin
                if (i_dp_stat.o_last) begin
                    n_st    = STAT_ACCEPTED;
                    n_state = ST_STAT;
                end else begin
                    o_dp_cmd.op = OP_INC_O;
                    n_state     = ST_P_RD;
                end
            end
            ST_STAT: begin
                if (i_dp_stat.out_free) begin
                    o_dp_cmd.op = OP_EMIT_STAT;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state and registered controls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_st      <= STAT_REJECTED;
            r_crossed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_st      <= n_st;
            r_crossed <= n_crossed;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// File: rtl/limit_order_book_matcher_core.sv
// Top level of the price-time priority limit order book matcher.
// Uses lobm_pkg, lobm_ctrl and lobm_datapath.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+--------------------------------
//   command  | in        | i_in_valid / o_in_ready    | command, id, side, price, qty, day
//   record   | out       | o_out_valid / i_out_ready  | kind, side, price, qty, status,
//            |           |                            | executed, remaining, last
//
// One command at a time, each completed before the next is taken; a cancel that
// empties its level adds a rescan. Matching reads each level in turn, then each
// resting order consumed from its head. A best price rescan reads one level entry
// at a time, up to 1024 entries; prune walks all 1024 slots, one at a time.
// After reset a clearing pass over all 2048 level entries runs before the first transfer.
// A full result register stalls the sequencer before each record.
module limit_order_book_matcher_core
    import lobm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_command,
    input  logic [ORD_AW-1:0]  i_order_id,
    input  logic               i_order_side,
    input  logic [PRICE_W-1:0] i_order_price,
    input  logic [QTY_W-1:0]   i_order_quantity,
    input  logic               i_good_for_day,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_record_kind,
    output logic               o_trade_side,
    output logic [PRICE_W-1:0] o_trade_price,
    output logic [QTY_W-1:0]   o_trade_quantity,
    output logic [2:0]         o_status,
    output logic [QTY_W-1:0]   o_executed_total,
    output logic [QTY_W-1:0]   o_remaining_quantity,
    output logic               o_last
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer
    lobm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_dp_stat  (dp_stat),
        .o_dp_cmd   (dp_cmd)
    );

    // stores and arithmetic
    lobm_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_dp_cmd             (dp_cmd),
        .o_dp_stat            (dp_stat),
        .i_command            (i_command),
        .i_order_id           (i_order_id),
        .i_order_side         (i_order_side),
        .i_order_price        (i_order_price),
        .i_order_quantity     (i_order_quantity),
        .i_good_for_day       (i_good_for_day),
        .i_out_ready          (i_out_ready),
        .o_out_valid          (o_out_valid),
        .o_record_kind        (o_record_kind),
        .o_trade_side         (o_trade_side),
        .o_trade_price        (o_trade_price),
        .o_trade_quantity     (o_trade_quantity),
        .o_status             (o_status),
        .o_executed_total     (o_executed_total),
        .o_remaining_quantity (o_remaining_quantity),
        .o_last               (o_last)
    );

endmodule
